// ----- rtl/vmd_pkg.sv -----
// Shared types, codes and reset values for the vibration motor drive level controller.
`timescale 1ns / 1ps

package vmd_pkg;

	localparam int LEVEL_W     = 7;
	localparam int TIME_W      = 32;
	localparam int INTENSITY_W = 16;
	localparam int CMD_W       = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int SWEEP_W     = 8;
	localparam int FRAC_W      = 14;
	localparam int SUM_W       = 22;

	// commands
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INCR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd4;

	localparam logic [6:0]  RST_FLOOR    = 7'd0;
	localparam logic [7:0]  RST_INTERVAL = 8'd5;
	localparam logic [15:0] RST_TIMEOUT  = 16'd200;
	localparam logic [6:0]  RST_INCR     = 7'd4;
	localparam logic [15:0] RST_HOLD     = 16'd700;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd127;
	localparam logic [LEVEL_W-1:0] FLOOR_LIMIT = 7'd126;
	localparam logic [FRAC_W:0]    FULL_SCALE  = 15'd16384;

	typedef struct packed {
		logic [6:0]  floor_level;
		logic [7:0]  write_interval;
		logic [15:0] idle_timeout;
		logic [6:0]  sweep_increment;
		logic [15:0] sweep_hold;
	} cfg_t;

	typedef struct packed {
		logic               write_strobe;
		logic [LEVEL_W-1:0] drive_level;
		logic               sweep_active;
		logic               sweep_finished;
	} result_t;

endpackage

// ----- rtl/vmd_level_map.sv -----
// Maps a Q2.14 intensity onto the floor..127 drive range with half-up rounding.
`timescale 1ns / 1ps

module vmd_level_map (
	input  logic signed [vmd_pkg::INTENSITY_W-1:0] intensity,
	input  logic [vmd_pkg::LEVEL_W-1:0]            floor_level,
	output logic                                   positive,
	output logic [vmd_pkg::LEVEL_W-1:0]            level
);

	logic [vmd_pkg::FRAC_W:0]   sat_v;
	logic [vmd_pkg::LEVEL_W-1:0] floor_c;
	logic [vmd_pkg::LEVEL_W-1:0] span;
	logic [vmd_pkg::SUM_W-1:0]   prod;
	logic [vmd_pkg::SUM_W-1:0]   sum;

	assign positive = !intensity[vmd_pkg::INTENSITY_W-1] && (intensity != '0);

	always_comb begin
		if (intensity[vmd_pkg::INTENSITY_W-2:0] > {1'b0, vmd_pkg::FULL_SCALE})
			sat_v = vmd_pkg::FULL_SCALE;
		else
			sat_v = intensity[vmd_pkg::FRAC_W:0];
		floor_c = (floor_level > vmd_pkg::FLOOR_LIMIT) ? vmd_pkg::FLOOR_LIMIT : floor_level;
		span    = vmd_pkg::LEVEL_MAX - floor_c;
		prod    = vmd_pkg::SUM_W'(sat_v) * vmd_pkg::SUM_W'(span);
		// floor * 16384 + v * (127 - floor) + half
		sum     = vmd_pkg::SUM_W'({floor_c, {vmd_pkg::FRAC_W{1'b0}}}) + prod
			+ vmd_pkg::SUM_W'(1 << (vmd_pkg::FRAC_W - 1));
		level   = sum[vmd_pkg::FRAC_W +: vmd_pkg::LEVEL_W];
	end

endmodule

// ----- rtl/vmd_core.sv -----
// Drive state, rate limit, idle timeout and sweep sequencing for one command per cycle.
`timescale 1ns / 1ps

module vmd_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic [vmd_pkg::CMD_W-1:0]          command,
	input  logic signed [vmd_pkg::INTENSITY_W-1:0] intensity,
	input  logic [vmd_pkg::TIME_W-1:0]         now_ms,
	input  vmd_pkg::cfg_t                      cfg,
	output vmd_pkg::result_t                   result
);

	logic [vmd_pkg::LEVEL_W-1:0] level_q, level_d;
	logic [vmd_pkg::TIME_W-1:0]  write_time_q, write_time_d;
	logic [vmd_pkg::TIME_W-1:0]  drive_time_q, drive_time_d;
	logic                        running_q, running_d;
	logic [vmd_pkg::SWEEP_W-1:0] sweep_lvl_q, sweep_lvl_d;
	logic [vmd_pkg::TIME_W-1:0]  step_time_q, step_time_d;

	logic                        set_pos;
	logic [vmd_pkg::LEVEL_W-1:0] set_level;
	logic [vmd_pkg::TIME_W-1:0]  since_write, since_drive, since_step;
	logic [vmd_pkg::SWEEP_W-1:0] sweep_top, sweep_next;
	logic                        strobe, finished;
	logic [vmd_pkg::LEVEL_W-1:0] put_val;

	vmd_level_map u_map (
		.intensity   (intensity),
		.floor_level (cfg.floor_level),
		.positive    (set_pos),
		.level       (set_level)
	);

	assign since_write = now_ms - write_time_q;
	assign since_drive = now_ms - drive_time_q;
	assign since_step  = now_ms - step_time_q;
	assign sweep_top   = vmd_pkg::SWEEP_W'(vmd_pkg::LEVEL_MAX - cfg.sweep_increment);
	assign sweep_next  = sweep_lvl_q + vmd_pkg::SWEEP_W'(cfg.sweep_increment);

	always_comb begin
		strobe       = 1'b0;
		finished     = 1'b0;
		put_val      = '0;
		running_d    = running_q;
		sweep_lvl_d  = sweep_lvl_q;
		step_time_d  = step_time_q;
		drive_time_d = drive_time_q;
		unique case (command)
			vmd_pkg::CMD_SET: begin
				if (!running_q) begin
					drive_time_d = now_ms;
					if (!set_pos) begin
						strobe = (level_q != '0);
					end else if (set_level != level_q &&
						since_write >= vmd_pkg::TIME_W'(cfg.write_interval)) begin
						strobe  = 1'b1;
						put_val = set_level;
					end
				end
			end
			vmd_pkg::CMD_TICK: begin
				if (running_q) begin
					if (since_step >= vmd_pkg::TIME_W'(cfg.sweep_hold)) begin
						step_time_d = now_ms;
						strobe      = 1'b1;
						if (sweep_lvl_q > sweep_top) begin
							running_d = 1'b0;
							finished  = 1'b1;
						end else begin
							sweep_lvl_d = sweep_next;
							put_val     = sweep_next[vmd_pkg::LEVEL_W-1:0];
						end
					end
				end else if (level_q != '0 &&
					since_drive > vmd_pkg::TIME_W'(cfg.idle_timeout)) begin
					strobe = 1'b1;
				end
			end
			vmd_pkg::CMD_STOP: begin
				running_d = 1'b0;
				strobe    = 1'b1;
			end
			vmd_pkg::CMD_SWEEP: begin
				running_d   = 1'b1;
				sweep_lvl_d = '0;
				step_time_d = now_ms;
				strobe      = 1'b1;
			end
			default: begin
			end
		endcase
		level_d      = strobe ? put_val : level_q;
		write_time_d = strobe ? now_ms : write_time_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			write_time_q <= '0;
			drive_time_q <= '0;
			running_q    <= 1'b0;
			sweep_lvl_q  <= '0;
			step_time_q  <= '0;
		end else if (advance) begin
			level_q      <= level_d;
			write_time_q <= write_time_d;
			drive_time_q <= drive_time_d;
			running_q    <= running_d;
			sweep_lvl_q  <= sweep_lvl_d;
			step_time_q  <= step_time_d;
		end
	end

	assign result.write_strobe   = strobe;
	assign result.drive_level    = level_d;
	assign result.sweep_active   = running_d;
	assign result.sweep_finished = finished;

endmodule

// ----- rtl/vibration_motor_drive_level_controller.sv -----
// Top level: configuration registers, input register and result register around the core.
`timescale 1ns / 1ps

// Takes one command per cycle and returns one result per command: the command is
// registered in the input register, the new drive level and sweep state are worked out
// combinationally (one 15x7 multiply for the set mapping plus three 32-bit time
// compares) and land in the result register. A full result register that is not being
// taken holds the input stage; the input side keeps accepting while the result
// register drains. Configuration writes take effect on the next clock edge.
module vibration_motor_drive_level_controller (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [vmd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [vmd_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [vmd_pkg::CMD_W-1:0]              command,
	input  logic signed [vmd_pkg::INTENSITY_W-1:0] intensity,
	input  logic [vmd_pkg::TIME_W-1:0]             now_ms,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   write_strobe,
	output logic [vmd_pkg::LEVEL_W-1:0]            drive_level,
	output logic                                   sweep_active,
	output logic                                   sweep_finished
);

	vmd_pkg::cfg_t cfg_q;

	logic                                   valid_s1;
	logic [vmd_pkg::CMD_W-1:0]              command_s1;
	logic signed [vmd_pkg::INTENSITY_W-1:0] intensity_s1;
	logic [vmd_pkg::TIME_W-1:0]             now_s1;
	logic                                   advance;
	vmd_pkg::result_t                       result_d;
	vmd_pkg::result_t                       result_q;
	logic                                   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_level     <= vmd_pkg::RST_FLOOR;
			cfg_q.write_interval  <= vmd_pkg::RST_INTERVAL;
			cfg_q.idle_timeout    <= vmd_pkg::RST_TIMEOUT;
			cfg_q.sweep_increment <= vmd_pkg::RST_INCR;
			cfg_q.sweep_hold      <= vmd_pkg::RST_HOLD;
		end else if (cfg_write) begin
			unique case (cfg_index)
				vmd_pkg::REG_FLOOR:    cfg_q.floor_level     <= cfg_data[6:0];
				vmd_pkg::REG_INTERVAL: cfg_q.write_interval  <= cfg_data[7:0];
				vmd_pkg::REG_TIMEOUT:  cfg_q.idle_timeout    <= cfg_data;
				vmd_pkg::REG_INCR:     cfg_q.sweep_increment <= cfg_data[6:0];
				vmd_pkg::REG_HOLD:     cfg_q.sweep_hold      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1   <= command;
			intensity_s1 <= intensity;
			now_s1       <= now_ms;
		end
	end

	vmd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.command   (command_s1),
		.intensity (intensity_s1),
		.now_ms    (now_s1),
		.cfg       (cfg_q),
		.result    (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result_d;
	end

	assign out_valid      = out_valid_q;
	assign write_strobe   = result_q.write_strobe;
	assign drive_level    = result_q.drive_level;
	assign sweep_active   = result_q.sweep_active;
	assign sweep_finished = result_q.sweep_finished;

endmodule

// ----- dv/drive_level_checker.sv -----
// Checker that predicts every drive result from the accepted commands and compares it.
`timescale 1ns / 1ps

module drive_level_checker
	import vmd_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [CMD_W-1:0]              command,
	input  logic signed [INTENSITY_W-1:0] intensity,
	input  logic [TIME_W-1:0]             now_ms,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          write_strobe,
	input  logic [LEVEL_W-1:0]            drive_level,
	input  logic                          sweep_active,
	input  logic                          sweep_finished,
	output int                            mismatches,
	output int                            outstanding
);

	logic [6:0]         floor_cfg;
	logic [7:0]         interval_cfg;
	logic [15:0]        timeout_cfg;
	logic [6:0]         incr_cfg;
	logic [15:0]        hold_cfg;

	logic [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0]  written_at;
	logic [TIME_W-1:0]  driven_at;
	logic [TIME_W-1:0]  step_at;
	logic               sweeping;
	logic [SWEEP_W-1:0] sweep_lvl;

	result_t            expected_results[$];
	result_t            want;
	result_t            predicted;
	int                 errs;

	assign mismatches = errs;

	task automatic put_level(input logic [LEVEL_W-1:0] lvl, input logic [TIME_W-1:0] t,
			inout result_t r);
		level_q = lvl;
		written_at = t;
		r.write_strobe = 1'b1;
	endtask

	task automatic step_drive(input logic [CMD_W-1:0] cmd,
			input logic signed [INTENSITY_W-1:0] inten, input logic [TIME_W-1:0] t,
			output result_t r);
		int unsigned f;
		int unsigned v;
		int unsigned lvl;
		r = '0;
		case (cmd)
			CMD_SET: begin
				if (!sweeping) begin
					driven_at = t;
					if (inten <= 0) begin
						if (level_q != 0)
							put_level('0, t, r);
					end else begin
						f = (floor_cfg > FLOOR_LIMIT) ? FLOOR_LIMIT : floor_cfg;
						v = inten;
						if (v > FULL_SCALE)
							v = FULL_SCALE;
						// map onto floor..127, round half up
						lvl = (f * FULL_SCALE + v * (LEVEL_MAX - f) + (FULL_SCALE >> 1)) >> FRAC_W;
						if (lvl != level_q && TIME_W'(t - written_at) >= interval_cfg)
							put_level(LEVEL_W'(lvl), t, r);
					end
				end
			end
			CMD_TICK: begin
				if (sweeping) begin
					if (TIME_W'(t - step_at) >= hold_cfg) begin
						step_at = t;
						if (int'(sweep_lvl) > int'(LEVEL_MAX) - int'(incr_cfg)) begin
							sweeping = 1'b0;
							put_level('0, t, r);
							r.sweep_finished = 1'b1;
						end else begin
							sweep_lvl = sweep_lvl + incr_cfg;
							put_level(sweep_lvl[LEVEL_W-1:0], t, r);
						end
					end
				end else if (level_q != 0 && TIME_W'(t - driven_at) > timeout_cfg) begin
					put_level('0, t, r);
				end
			end
			CMD_STOP: begin
				sweeping = 1'b0;
				put_level('0, t, r);
			end
			default: begin
				sweeping = 1'b1;
				sweep_lvl = '0;
				step_at = t;
				put_level('0, t, r);
			end
		endcase
		r.drive_level = level_q;
		r.sweep_active = sweeping;
	endtask

	task automatic report(input string field, input int unsigned exp_val, input int unsigned got);
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val, got);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_cfg = RST_FLOOR;
			interval_cfg = RST_INTERVAL;
			timeout_cfg = RST_TIMEOUT;
			incr_cfg = RST_INCR;
			hold_cfg = RST_HOLD;
			level_q = '0;
			written_at = '0;
			driven_at = '0;
			step_at = '0;
			sweeping = 1'b0;
			sweep_lvl = '0;
			expected_results.delete();
			errs = 0;
			outstanding <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FLOOR:    floor_cfg = cfg_data[6:0];
					REG_INTERVAL: interval_cfg = cfg_data[7:0];
					REG_TIMEOUT:  timeout_cfg = cfg_data[15:0];
					REG_INCR:     incr_cfg = cfg_data[6:0];
					REG_HOLD:     hold_cfg = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual level %0d strobe %0d",
						$time, drive_level, write_strobe);
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (want.write_strobe !== write_strobe)
						report("write_strobe", want.write_strobe, write_strobe);
					if (want.drive_level !== drive_level)
						report("drive_level", want.drive_level, drive_level);
					if (want.sweep_active !== sweep_active)
						report("sweep_active", want.sweep_active, sweep_active);
					if (want.sweep_finished !== sweep_finished)
						report("sweep_finished", want.sweep_finished, sweep_finished);
				end
			end
			if (in_valid && in_ready) begin
				step_drive(command, intensity, now_ms, predicted);
				expected_results.push_back(predicted);
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// ----- dv/vibration_motor_drive_level_controller_tb.sv -----
// Testbench top: clock, reset, command and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module vibration_motor_drive_level_controller_tb;
	import vmd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 80;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_write;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [CMD_W-1:0]              command;
	logic signed [INTENSITY_W-1:0] intensity;
	logic [TIME_W-1:0]             now_ms;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          write_strobe;
	logic [LEVEL_W-1:0]            drive_level;
	logic                          sweep_active;
	logic                          sweep_finished;

	int                            mismatches;
	int                            outstanding;
	int                            cycle_count = 0;
	int                            items_sent = 0;
	int unsigned                   send_idle = 0;
	int unsigned                   recv_idle = 0;

	// stimulus-side copy of the interval, timeout, increment and hold registers, used to aim time steps at thresholds
	int unsigned                   c_interval = RST_INTERVAL;
	int unsigned                   c_timeout = RST_TIMEOUT;
	int unsigned                   c_incr = RST_INCR;
	int unsigned                   c_hold = RST_HOLD;
	logic [TIME_W-1:0]             ms_now;

	vibration_motor_drive_level_controller dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.intensity      (intensity),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_strobe   (write_strobe),
		.drive_level    (drive_level),
		.sweep_active   (sweep_active),
		.sweep_finished (sweep_finished)
	);

	drive_level_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.intensity      (intensity),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_strobe   (write_strobe),
		.drive_level    (drive_level),
		.sweep_active   (sweep_active),
		.sweep_finished (sweep_finished),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= (recv_idle == 0) ? 1'b1 : ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [TIME_W-1:0] near(input int unsigned mark);
		int unsigned off;
		off = $urandom_range(0, 6);
		return (mark + off < 3) ? '0 : TIME_W'(mark + off - 3);
	endfunction

	function automatic logic [TIME_W-1:0] pick_gap();
		case ($urandom_range(0, 9))
			0:       return '0;
			1, 2:    return $urandom_range(0, 8);
			3:       return near(c_interval);
			4:       return near(c_timeout);
			5:       return near(c_hold);
			6:       return $urandom_range(0, 70000);
			7:       return $urandom();
			default: return $urandom_range(0, 300);
		endcase
	endfunction

	function automatic logic signed [INTENSITY_W-1:0] pick_intensity();
		case ($urandom_range(0, 9))
			0:       return INTENSITY_W'($urandom_range(FULL_SCALE + 1, 32767));
			1:       return INTENSITY_W'(0 - $urandom_range(0, 32768));
			2:       return INTENSITY_W'($urandom());
			default: return INTENSITY_W'($urandom_range(1, FULL_SCALE));
		endcase
	endfunction

	task automatic send(input logic [CMD_W-1:0] c, input logic signed [INTENSITY_W-1:0] v,
			input logic [TIME_W-1:0] t);
		while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		intensity <= v;
		now_ms <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// wait until every expected result has been through the output transfer
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input int unsigned val,
			input int width);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		// junk above the register width must be dropped
		cfg_data <= CFG_DATA_W'(($urandom() << width) | val);
		@(posedge clk);
	endtask

	task automatic program_regs(input int unsigned fl, input int unsigned iv,
			input int unsigned to, input int unsigned inc, input int unsigned hd);
		cfg_put(REG_FLOOR, fl, 7);
		cfg_put(REG_INTERVAL, iv, 8);
		cfg_put(REG_TIMEOUT, to, 16);
		cfg_put(REG_INCR, inc, 7);
		cfg_put(REG_HOLD, hd, 16);
		cfg_put(CFG_IDX_W'($urandom_range(REG_HOLD + 1, (1 << CFG_IDX_W) - 1)), $urandom(), 0);
		cfg_write <= 1'b0;
		c_interval = iv;
		c_timeout = to;
		c_incr = inc;
		c_hold = hd;
	endtask

	initial begin
		int phase;
		int goal;
		int burst;
		int steps;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_FLOOR;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_SET;
		intensity = '0;
		now_ms = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		send(CMD_SET, 16384, 10);
		send(CMD_SET, 32767, 12);
		send(CMD_SET, 8192, 13);
		send(CMD_SET, 8192, 15);
		send(CMD_SET, 1, 100);
		send(CMD_SET, -32768, 101);
		send(CMD_SET, 16385, 110);
		send(CMD_SET, 0, 111);
		send(CMD_SET, 129, 300);
		send(CMD_TICK, 0, 500);
		send(CMD_TICK, 0, 501);
		send(CMD_SET, 128, 600);
		send(CMD_SET, -1, 601);
		send(CMD_SWEEP, 16384, 700);
		send(CMD_SET, 16384, 710);
		send(CMD_TICK, 0, 1399);
		send(CMD_TICK, 0, 1400);
		send(CMD_STOP, 0, 1401);
		send(CMD_STOP, 0, 1402);
		// sweep hold measured across the 32-bit time wrap
		send(CMD_SWEEP, -32768, 32'hFFFF_FE00);
		send(CMD_SET, 16384, 32'hFFFF_FF00);
		send(CMD_TICK, 0, 32'h0000_00BB);
		send(CMD_TICK, -1, 32'h0000_00BC);
		send(CMD_STOP, 32767, 32'h0000_00BD);
		ms_now = 32'h0000_00BD;

		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				1: program_regs(127, 0, 0, 127, 0);
				2: program_regs(126, 255, 65535, 1, 65535);
				4: program_regs(0, 3, 50, 0, 10);
				3, 5: program_regs($urandom_range(0, 127), $urandom_range(0, 255),
						$urandom_range(0, 2000), $urandom_range(1, 127), $urandom_range(0, 1500));
				default: ;
			endcase
			if (phase >= 3)
				ms_now = $urandom();
			send_idle = (phase < 2) ? 23 : (phase < 4) ? 66 : 0;
			recv_idle <= (phase < 2) ? 66 : (phase < 4) ? 23 : 0;
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6: begin
						burst = $urandom_range(1, 6);
						repeat (burst) begin
							ms_now += pick_gap();
							send(CMD_SET, pick_intensity(), ms_now);
						end
					end
					7, 8, 9, 10: begin
						ms_now += $urandom_range(0, 1) ? near(c_timeout) : pick_gap();
						send(CMD_TICK, INTENSITY_W'($urandom()), ms_now);
					end
					11, 12, 13, 14: begin
						send(CMD_SWEEP, pick_intensity(), ms_now);
						steps = (c_incr == 0) ? 6 : LEVEL_MAX / c_incr + 6;
						if (steps > 48)
							steps = 48;
						repeat (steps) begin
							case ($urandom_range(0, 7))
								0: ms_now += $urandom_range(0, c_hold);
								1: begin
									// set during a sweep is dropped
									ms_now += pick_gap();
									send(CMD_SET, pick_intensity(), ms_now);
								end
								default: ms_now += c_hold + $urandom_range(0, 3);
							endcase
							send(CMD_TICK, pick_intensity(), ms_now);
						end
						if ($urandom_range(0, 2) == 0) begin
							ms_now += pick_gap();
							send(CMD_STOP, pick_intensity(), ms_now);
						end
					end
					default: begin
						ms_now += pick_gap();
						send(CMD_W'($urandom()), INTENSITY_W'($urandom()), ms_now);
					end
				endcase
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
